// File: rtl/core/mrab_pkg.sv
// Shared types, constants and byte-order helpers for the Merkle root and branch engine.
`timescale 1ns / 1ps
package mrab_pkg;

  localparam int unsigned MAX_LEVELS_DEF = 32;
  localparam int unsigned CFG_IDX_W      = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_POS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRANCH_EN  = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_BRANCH = 2'd0;
  localparam logic [1:0] KIND_ROOT   = 2'd1;
  localparam logic [1:0] KIND_OVF    = 2'd2;

  typedef logic [3:0][63:0]  hash_t;
  typedef logic [7:0][31:0]  state8_t;
  typedef logic [15:0][31:0] word16_t;

  typedef struct packed {
    logic [63:0] leaf_word0;
    logic [63:0] leaf_word1;
    logic [63:0] leaf_word2;
    logic [63:0] leaf_word3;
    logic        last_leaf;
    logic        empty_set;
  } leaf_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] hash_word0;
    logic [63:0] hash_word1;
    logic [63:0] hash_word2;
    logic [63:0] hash_word3;
    logic        mutated;
    logic        last_result;
  } result_t;

  localparam state8_t SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // first block: bytes of left then right, big-endian words
  function automatic word16_t pack_block(hash_t l, hash_t r);
    word16_t b;
    hash_t   src;
    int      wi;
    int      off;
    for (int i = 0; i < 16; i++) begin
      src = (i < 8) ? l : r;
      wi  = (i % 8) / 2;
      off = (i % 2) * 4;
      b[i] = {src[wi][8*off +: 8], src[wi][8*(off+1) +: 8],
              src[wi][8*(off+2) +: 8], src[wi][8*(off+3) +: 8]};
    end
    return b;
  endfunction

  function automatic word16_t pad_block();
    word16_t b;
    b     = '0;
    b[0]  = 32'h80000000;
    b[15] = 32'd512;
    return b;
  endfunction

  function automatic word16_t digest_block(state8_t s);
    word16_t b;
    b = '0;
    for (int i = 0; i < 8; i++) b[i] = s[i];
    b[8]  = 32'h80000000;
    b[15] = 32'd256;
    return b;
  endfunction

  function automatic hash_t digest_to_hash(state8_t s);
    hash_t h;
    for (int j = 0; j < 32; j++) begin
      h[j/8][8*(j%8) +: 8] = s[j/4][24-8*(j%4) +: 8];
    end
    return h;
  endfunction

endpackage

// File: rtl/core/mrab_sha_rnd.sv
// SHA-256 compression, one round per clock, rolling 16-word message schedule.
`timescale 1ns / 1ps
module mrab_sha_rnd (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mrab_pkg::state8_t st_i,
  input  mrab_pkg::word16_t blk_i,
  output logic              done_o,
  output mrab_pkg::state8_t st_o
);
  import mrab_pkg::*;

  state8_t     v_q, v_d, init_q;
  word16_t     w_q, w_d;
  logic [5:0]  rnd_q;
  logic        busy_q, fin_q;
  logic [31:0] s0, s1, ch, mj, t1, t2, ws0, ws1;

  always_comb begin
    s1  = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1  = v_q[7] + s1 + ch + K_TAB[rnd_q] + w_q[0];
    s0  = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2  = s0 + mj;
    v_d = {v_q[6], v_q[5], v_q[4], v_q[3] + t1, v_q[2], v_q[1], v_q[0], t1 + t2};
    ws0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    ws1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    w_d = {w_q[0] + ws0 + w_q[9] + ws1, w_q[15:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      rnd_q  <= '0;
    end else begin
      fin_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q    <= st_i;
      init_q <= st_i;
      w_q    <= blk_i;
    end else if (busy_q) begin
      v_q <= v_d;
      w_q <= w_d;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) st_o[i] = init_q[i] + v_q[i];
  end

  assign done_o = fin_q;

endmodule

// File: rtl/core/mrab_dsha.sv
// Pair combine: double SHA-256 of two hashes as three passes of the compression unit.
`timescale 1ns / 1ps
module mrab_dsha (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  mrab_pkg::hash_t left_i,
  input  mrab_pkg::hash_t right_i,
  output logic            done_o,
  output mrab_pkg::hash_t hash_o
);
  import mrab_pkg::*;

  localparam logic [1:0] P_MSG = 2'd0;
  localparam logic [1:0] P_PAD = 2'd1;
  localparam logic [1:0] P_OUT = 2'd2;

  logic [1:0] pass_q;
  logic       c_start, c_done;
  state8_t    c_st, c_out;
  word16_t    c_blk;

  always_comb begin
    c_start = start_i || (c_done && pass_q != P_OUT);
    if (start_i) begin
      c_st  = SHA_IV;
      c_blk = pack_block(left_i, right_i);
    end else if (pass_q == P_MSG) begin
      c_st  = c_out;
      c_blk = pad_block();
    end else begin
      c_st  = SHA_IV;
      c_blk = digest_block(c_out);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= P_MSG;
    end else if (start_i) begin
      pass_q <= P_MSG;
    end else if (c_done && pass_q != P_OUT) begin
      pass_q <= pass_q + 2'd1;
    end
  end

  mrab_sha_rnd u_rnd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (c_start),
    .st_i    (c_st),
    .blk_i   (c_blk),
    .done_o  (c_done),
    .st_o    (c_out)
  );

  assign done_o = c_done && pass_q == P_OUT;
  assign hash_o = digest_to_hash(c_out);

endmodule

// File: rtl/core/merkle_root_and_branch.sv
// Streaming Merkle root and branch engine: top level with sequencer and subtree store.
`timescale 1ns / 1ps
// Leaf hashes arrive one beat at a time; one subtree hash is kept per tree level in a
// small RAM and pairs are merged with double SHA-256 as soon as both halves exist.
// For the leaf at branch_position, when branch output is enabled, the sibling hashes
// on its path are sent as branch beats (kind 0) from the bottom level up; the beat
// carrying last_leaf also runs the final sweep, pairing odd nodes with themselves, and
// ends with the root beat (kind 1) whose mutated flag marks any equal pair merged as
// leaves were added. empty_set gives one all-zero root; a leaf past 2^MAX_LEVELS-1
// aborts the set with one kind 2 beat. Every combine runs on one shared compression
// unit: three passes of 64 rounds plus handover. A leaf causes one merge per pair it
// completes (one on average), the final sweep one per level above the lowest kept
// subtree; in_ready is low meanwhile. Results pass through a one-deep hold stage and
// an output register, so last_result is known when a beat is presented; the engine
// only waits on out_ready when both are full. Configuration writes are always accepted;
// the user must make them between leaves to act from the next leaf (not enforced here).
module merkle_root_and_branch #(
  parameter int unsigned MAX_LEVELS = mrab_pkg::MAX_LEVELS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  mrab_pkg::leaf_t                  in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output mrab_pkg::result_t                out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mrab_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i
);
  import mrab_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned AW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned CW = MAX_LEVELS + 1;
  localparam logic [LW-1:0] LVL_MAX  = LW'(MAX_LEVELS);
  localparam logic [LW-1:0] LVL_TOP  = LW'(MAX_LEVELS - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_A_CHK  = 4'd1;
  localparam logic [3:0] S_A_KEPT = 4'd2;
  localparam logic [3:0] S_A_CMB  = 4'd3;
  localparam logic [3:0] S_A_ST   = 4'd4;
  localparam logic [3:0] S_B_SCAN = 4'd5;
  localparam logic [3:0] S_B_LOAD = 4'd6;
  localparam logic [3:0] S_B_CHK  = 4'd7;
  localparam logic [3:0] S_B_CMB  = 4'd8;
  localparam logic [3:0] S_B_INN  = 4'd9;
  localparam logic [3:0] S_B_KEPT = 4'd10;
  localparam logic [3:0] S_B_ICMB = 4'd11;
  localparam logic [3:0] S_FIN    = 4'd12;

  typedef struct packed {
    logic [1:0] kind;
    hash_t      hash;
    logic       mut;
  } emit_t;

  // sequencer state
  logic [3:0]            state_q, state_d;
  logic [LW-1:0]         lvl_q, lvl_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  hash_t                 h_q, h_d;
  logic                  matchh_q, matchh_d;
  logic                  last_q, last_d;
  logic [MAX_LEVELS-1:0] leaf_cnt_q, leaf_cnt_d;
  logic                  mvalid_q, mvalid_d;
  logic [LW-1:0]         mlvl_q, mlvl_d;
  logic                  mut_q, mut_d;
  logic [31:0]           pos_q;
  logic                  en_q;

  // subtree store
  hash_t                 mem_q [MAX_LEVELS];
  hash_t                 rd_q;
  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_ra, mem_wa;
  logic [LW-1:0]         lvl_st;

  // combine unit
  logic                  cmb_start, cmb_done;
  hash_t                 cmb_res, cmb_left;

  // result path
  logic                  emit_do, flush_do, push_do, can_emit, slot_free;
  emit_t                 emit_v, pend_q;
  logic                  pend_valid_q, out_valid_q;
  result_t               out_q;

  logic                  kept_em, kept_hit;
  hash_t                 leaf_h;

  assign leaf_h = {in_data_i.leaf_word3, in_data_i.leaf_word2,
                   in_data_i.leaf_word1, in_data_i.leaf_word0};

  assign slot_free = !out_valid_q || out_ready_i;
  assign can_emit  = !pend_valid_q || slot_free;
  assign push_do   = (emit_do && pend_valid_q) || flush_do;

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign lvl_st   = (lvl_q >= LVL_MAX) ? LVL_TOP : lvl_q;
  assign cmb_left = (state_q == S_B_CHK) ? h_q : rd_q;

  // a kept node on the path: either we are on it, or the chosen leaf's subtree sits here
  assign kept_hit = !matchh_q && mvalid_q && (mlvl_q == lvl_q);
  assign kept_em  = en_q && (matchh_q || kept_hit);

  always_comb begin
    state_d    = state_q;
    lvl_d      = lvl_q;
    cnt_d      = cnt_q;
    h_d        = h_q;
    matchh_d   = matchh_q;
    last_d     = last_q;
    leaf_cnt_d = leaf_cnt_q;
    mvalid_d   = mvalid_q;
    mlvl_d     = mlvl_q;
    mut_d      = mut_q;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_ra     = lvl_q[AW-1:0];
    mem_wa     = lvl_st[AW-1:0];
    cmb_start  = 1'b0;
    emit_do    = 1'b0;
    emit_v     = '{kind: KIND_BRANCH, hash: rd_q, mut: 1'b0};
    flush_do   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.empty_set || leaf_cnt_q == '1) begin
            emit_do    = 1'b1;
            emit_v     = '{kind: in_data_i.empty_set ? KIND_ROOT : KIND_OVF,
                           hash: '0, mut: 1'b0};
            leaf_cnt_d = '0;
            mvalid_d   = 1'b0;
            mut_d      = 1'b0;
            state_d    = S_FIN;
          end else begin
            h_d      = leaf_h;
            last_d   = in_data_i.last_leaf;
            matchh_d = (32'(leaf_cnt_q) == pos_q);
            cnt_d    = CW'(leaf_cnt_q) + CW'(1);
            lvl_d    = '0;
            state_d  = S_A_CHK;
          end
        end
      end
      S_A_CHK: begin
        if (lvl_q < LVL_MAX && !cnt_q[lvl_q]) begin
          mem_re  = 1'b1;
          state_d = S_A_KEPT;
        end else begin
          state_d = S_A_ST;
        end
      end
      S_A_KEPT: begin
        if (!kept_em || can_emit) begin
          emit_do = kept_em;
          emit_v  = '{kind: KIND_BRANCH, hash: matchh_q ? rd_q : h_q, mut: 1'b0};
          if (kept_hit) matchh_d = 1'b1;
          if (rd_q == h_q) mut_d = 1'b1;
          cmb_start = 1'b1;
          state_d   = S_A_CMB;
        end
      end
      S_A_CMB: begin
        if (cmb_done) begin
          h_d     = cmb_res;
          lvl_d   = lvl_q + LW'(1);
          state_d = S_A_CHK;
        end
      end
      S_A_ST: begin
        mem_we     = 1'b1;
        leaf_cnt_d = cnt_q[MAX_LEVELS-1:0];
        if (matchh_q) begin
          mvalid_d = 1'b1;
          mlvl_d   = lvl_st;
        end
        lvl_d   = '0;
        state_d = last_q ? S_B_SCAN : S_FIN;
      end
      S_B_SCAN: begin
        if (lvl_q < LVL_TOP && !cnt_q[lvl_q]) begin
          lvl_d = lvl_q + LW'(1);
        end else begin
          mem_re  = 1'b1;
          state_d = S_B_LOAD;
        end
      end
      S_B_LOAD: begin
        h_d      = rd_q;
        matchh_d = mvalid_q && (mlvl_q == lvl_q);
        state_d  = S_B_CHK;
      end
      S_B_CHK: begin
        if (lvl_q < LVL_MAX && cnt_q != (CW'(1) << lvl_q)) begin
          // odd node: pair with itself
          if (!(matchh_q && en_q) || can_emit) begin
            emit_do   = matchh_q && en_q;
            emit_v    = '{kind: KIND_BRANCH, hash: h_q, mut: 1'b0};
            cmb_start = 1'b1;
            state_d   = S_B_CMB;
          end
        end else if (can_emit) begin
          emit_do    = 1'b1;
          emit_v     = '{kind: KIND_ROOT, hash: h_q, mut: mut_q};
          leaf_cnt_d = '0;
          mvalid_d   = 1'b0;
          mut_d      = 1'b0;
          state_d    = S_FIN;
        end
      end
      S_B_CMB: begin
        if (cmb_done) begin
          h_d     = cmb_res;
          cnt_d   = cnt_q + (CW'(1) << lvl_q);
          lvl_d   = lvl_q + LW'(1);
          state_d = S_B_INN;
        end
      end
      S_B_INN: begin
        if (lvl_q < LVL_MAX && !cnt_q[lvl_q]) begin
          mem_re  = 1'b1;
          state_d = S_B_KEPT;
        end else begin
          state_d = S_B_CHK;
        end
      end
      S_B_KEPT: begin
        if (!kept_em || can_emit) begin
          emit_do = kept_em;
          emit_v  = '{kind: KIND_BRANCH, hash: matchh_q ? rd_q : h_q, mut: 1'b0};
          if (kept_hit) matchh_d = 1'b1;
          cmb_start = 1'b1;
          state_d   = S_B_ICMB;
        end
      end
      S_B_ICMB: begin
        if (cmb_done) begin
          h_d     = cmb_res;
          lvl_d   = lvl_q + LW'(1);
          state_d = S_B_INN;
        end
      end
      S_FIN: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          flush_do = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lvl_q        <= '0;
      cnt_q        <= '0;
      matchh_q     <= 1'b0;
      last_q       <= 1'b0;
      leaf_cnt_q   <= '0;
      mvalid_q     <= 1'b0;
      mlvl_q       <= '0;
      mut_q        <= 1'b0;
      pos_q        <= '0;
      en_q         <= 1'b1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      lvl_q      <= lvl_d;
      cnt_q      <= cnt_d;
      matchh_q   <= matchh_d;
      last_q     <= last_d;
      leaf_cnt_q <= leaf_cnt_d;
      mvalid_q   <= mvalid_d;
      mlvl_q     <= mlvl_d;
      mut_q      <= mut_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_BRANCH_POS: pos_q <= cfg_data_i;
          CFG_BRANCH_EN:  en_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (emit_do) begin
        pend_valid_q <= 1'b1;
      end else if (flush_do) begin
        pend_valid_q <= 1'b0;
      end
      if (push_do) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    h_q <= h_d;
    if (emit_do) pend_q <= emit_v;
    if (push_do) begin
      out_q.result_kind <= pend_q.kind;
      out_q.hash_word0  <= pend_q.hash[0];
      out_q.hash_word1  <= pend_q.hash[1];
      out_q.hash_word2  <= pend_q.hash[2];
      out_q.hash_word3  <= pend_q.hash[3];
      out_q.mutated     <= pend_q.mut;
      out_q.last_result <= flush_do;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= h_q;
    if (mem_re) rd_q <= mem_q[mem_ra];
  end

  mrab_dsha u_dsha (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmb_start),
    .left_i  (cmb_left),
    .right_i (h_q),
    .done_o  (cmb_done),
    .hash_o  (cmb_res)
  );

endmodule
